FILE: src/s8lfr_pkg.sv
// Shared types and constants for the sum8 length-prefixed frame receiver.
package s8lfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] LenCap = 8'd251;
  localparam logic [ByteW-1:0] Mark1Rst = 8'h55;
  localparam logic [ByteW-1:0] Mark2Rst = 8'haa;

  // Byte positions of the fixed header fields.
  localparam logic [ByteW-1:0] PosMark2 = 8'd1;
  localparam logic [ByteW-1:0] PosLen = 8'd2;
  localparam logic [ByteW-1:0] PosId = 8'd3;
  localparam logic [ByteW-1:0] PosCmd = 8'd4;
  // Bytes ahead of the body: two marks and the length.
  localparam logic [ByteW:0] HdrBytes = 9'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMark1 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMark2 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLen = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT1 = 5'b00001,
    PH_HUNT2 = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_BODY  = 5'b01000,
    PH_SUM   = 5'b10000
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_HUNT    = 3'd0,
    EV_START   = 3'd1,
    EV_LEN_OK  = 3'd2,
    EV_LEN_BAD = 3'd3,
    EV_BODY    = 3'd4,
    EV_GOOD    = 3'd5,
    EV_BAD     = 3'd6
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] mark1;
    logic [ByteW-1:0] mark2;
    logic [ByteW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [ByteW-1:0] count;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] cmd;
  } frm_state_t;

  typedef struct packed {
    event_e           ev;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] pos;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] cmd;
  } result_t;

endpackage

FILE: src/s8lfr_if.sv
// Valid/ready channels for received bytes and per-byte event items.
interface s8lfr_byte_if;
  import s8lfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface s8lfr_event_if;
  import s8lfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic [ByteW-1:0]  byte_value;
  logic [ByteW-1:0]  byte_position;
  logic [ByteW-1:0]  frame_length;
  logic [ByteW-1:0]  frame_id;
  logic [ByteW-1:0]  frame_command;
  modport source (output valid, output event_res, output byte_value, output byte_position,
                  output frame_length, output frame_id, output frame_command, input ready);
  modport sink (input valid, input event_res, input byte_value, input byte_position,
                input frame_length, input frame_id, input frame_command, output ready);
endinterface

FILE: src/s8lfr_step.sv
// Next-state and event logic of the deframer for one received byte.
module s8lfr_step (
  input  s8lfr_pkg::frm_state_t     state_i,
  input  s8lfr_pkg::cfg_t           cfg_i,
  input  logic [s8lfr_pkg::ByteW-1:0] byte_i,
  output s8lfr_pkg::frm_state_t     state_o,
  output s8lfr_pkg::result_t        res_o
);
  import s8lfr_pkg::*;

  logic [ByteW-1:0] count_inc;
  logic [ByteW:0]   body_end;
  logic             len_ok;

  assign count_inc = state_i.count + 8'd1;
  assign body_end  = {1'b0, state_i.len} + HdrBytes + 9'd1;
  assign len_ok    = (byte_i <= cfg_i.max_len) && (byte_i <= LenCap);

  always_comb begin
    state_o   = state_i;
    res_o.ev    = EV_HUNT;
    res_o.value = byte_i;
    res_o.pos   = '0;
    res_o.len   = '0;
    res_o.id    = '0;
    res_o.cmd   = '0;

    unique case (state_i.phase)
      PH_HUNT1: begin
        if (byte_i == cfg_i.mark1) begin
          res_o.ev      = EV_START;
          state_o.phase = PH_HUNT2;
          state_o.count = PosMark2;
        end else begin
          state_o.phase = PH_HUNT1;
          state_o.count = '0;
        end
      end
      PH_HUNT2: begin
        if (byte_i == cfg_i.mark2) begin
          res_o.ev      = EV_START;
          res_o.pos     = PosMark2;
          state_o.phase = PH_LEN;
          state_o.count = PosLen;
        end else begin
          state_o.phase = PH_HUNT1;
          state_o.count = '0;
        end
      end
      PH_LEN: begin
        res_o.pos   = PosLen;
        res_o.len   = byte_i;
        state_o.len = byte_i;
        state_o.sum = byte_i;
        if (len_ok) begin
          res_o.ev      = EV_LEN_OK;
          state_o.id    = '0;
          state_o.cmd   = '0;
          state_o.phase = PH_BODY;
          state_o.count = PosId;
        end else begin
          res_o.ev      = EV_LEN_BAD;
          state_o.phase = PH_HUNT1;
          state_o.count = '0;
        end
      end
      PH_BODY: begin
        res_o.ev      = EV_BODY;
        res_o.pos     = state_i.count;
        res_o.len     = state_i.len;
        state_o.sum   = state_i.sum + byte_i;
        if (state_i.count == PosId) state_o.id = byte_i;
        if (state_i.count == PosCmd) state_o.cmd = byte_i;
        state_o.count = count_inc;
        // Last body byte seen: next byte is the checksum.
        if ({1'b0, count_inc} >= body_end) state_o.phase = PH_SUM;
      end
      PH_SUM: begin
        res_o.ev      = (state_i.sum == byte_i) ? EV_GOOD : EV_BAD;
        res_o.pos     = state_i.count;
        res_o.len     = state_i.len;
        res_o.id      = state_i.id;
        res_o.cmd     = state_i.cmd;
        state_o.phase = PH_HUNT1;
        state_o.count = '0;
      end
      default: begin
        state_o.phase = PH_HUNT1;
        state_o.count = '0;
      end
    endcase
  end

endmodule

FILE: src/sum8_length_frame_receiver.sv
// Top level of the sum8 length-prefixed frame receiver.
//
//  channel   dir  payload                                   handshake
//  rx_i      in   rx_byte                                   valid/ready
//  res_o     out  event_res, byte_value, byte_position,     valid/ready
//                 frame_length, frame_id, frame_command
//  cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i, no wait
//
// Each accepted byte updates the frame state and lands
// in the result register at the same edge, so a new byte is taken every
// cycle while the result register is empty or being drained.
// Reset (rst_ni low, async) returns to hunting for the first start byte,
// clears all frame state and loads the default marks and length limit.
// A stall on res_o holds the result and deasserts rx_i.ready; nothing else
// waits on it.
module sum8_length_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [s8lfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [s8lfr_pkg::ByteW-1:0]   cfg_data_i,
  s8lfr_byte_if.sink                    rx_i,
  s8lfr_event_if.source                 res_o
);
  import s8lfr_pkg::*;

  cfg_t       cfg_q;
  frm_state_t state_q, state_d;
  result_t    res_d, res_q;
  logic       res_vld_q;
  logic       take;

  // Config registers; unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark1   <= Mark1Rst;
      cfg_q.mark2   <= Mark2Rst;
      cfg_q.max_len <= LenCap;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMark1:  cfg_q.mark1   <= cfg_data_i;
        CfgMark2:  cfg_q.mark2   <= cfg_data_i;
        CfgMaxLen: cfg_q.max_len <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  s8lfr_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .byte_i  (rx_i.rx_byte),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Result register frees up in the same cycle it is read.
  assign rx_i.ready = !res_vld_q || res_o.ready;
  assign take       = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase <= PH_HUNT1;
      state_q.count <= '0;
      state_q.len   <= '0;
      state_q.sum   <= '0;
      state_q.id    <= '0;
      state_q.cmd   <= '0;
      res_vld_q     <= 1'b0;
    end else begin
      if (take) begin
        state_q   <= state_d;
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.event_res     = res_q.ev;
  assign res_o.byte_value    = res_q.value;
  assign res_o.byte_position = res_q.pos;
  assign res_o.frame_length  = res_q.len;
  assign res_o.frame_id      = res_q.id;
  assign res_o.frame_command = res_q.cmd;

endmodule
